// ===== hdl/hssk_pkg.sv =====
package hssk_pkg;

  localparam int TIMER_WIDTH = 16;

  // input actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;
  localparam logic [1:0] ACT_DONE  = 2'd3;

  // sensor phases
  localparam logic [2:0] PH_STARTUP   = 3'd0;
  localparam logic [2:0] PH_IDLE      = 3'd1;
  localparam logic [2:0] PH_MEASURING = 3'd2;
  localparam logic [2:0] PH_READING   = 3'd3;
  localparam logic [2:0] PH_FINISH    = 3'd4;
  localparam logic [2:0] PH_READY     = 3'd5;
  localparam logic [2:0] PH_ERROR     = 3'd6;

  // measurement status
  localparam logic [1:0] MEAS_OK    = 2'd0;
  localparam logic [1:0] MEAS_STALE = 2'd1;
  localparam logic [1:0] MEAS_ERROR = 2'd2;

  // start answers
  localparam logic [1:0] START_ACCEPTED = 2'd0;
  localparam logic [1:0] START_NOT_IDLE = 2'd1;
  localparam logic [1:0] START_REFUSED  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_STARTUP = 2'd0;
  localparam logic [1:0] REG_MEASURE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [15:0] STARTUP_RST = 16'd50;
  localparam logic [15:0] MEASURE_RST = 16'd40;
  localparam logic [15:0] TIMEOUT_RST = 16'd10;

  // scaling
  localparam logic [14:0] HUM_SCALE   = 15'(100 * 100);
  localparam logic [14:0] TEMP_SCALE  = 15'(165 * 100);
  localparam logic [15:0] TEMP_OFFSET = 16'd4000;
  localparam int          FRAC_BITS   = 14;

  localparam logic signed [15:0] MANT_MAX = 16'sd1023;
  localparam logic signed [15:0] MANT_MIN = -16'sd1023;

  localparam logic [15:0] RAW_ERR = 16'hffff;
  localparam logic [15:0] KNX_ERR = 16'h7fff;

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  // sign, 4-bit exponent, low 11 mantissa bits
  function automatic logic [15:0] knx_pack(input logic signed [15:0] mant,
                                           input logic [3:0] expo);
    knx_pack = {mant[15], expo, mant[10:0]};
  endfunction

  // saturating load of a 16-bit register into the wait counter
  function automatic tmr_t tmr_load(input logic [15:0] v);
    logic [31:0] wide;
    logic [31:0] lim;
    wide = {16'd0, v};
    lim  = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
    tmr_load = (wide > lim) ? tmr_t'(lim) : tmr_t'(wide);
  endfunction

endpackage

// ===== hdl/humidity_sensor_sequencer_knx.sv =====
// result: registered and valid in the cycle after an accepted item, for every item except
//   a tick in the finish phase with an ok or stale word, which first passes twice through
//   the shared multiplier, then takes one normalizing shift per cycle for each float
// throughput: one item at a time; the input is ready again once the result is taken
// reset: synchronous active-low rst_n; registers back to defaults, phase idle,
//   stored result zero, no clearing pass
module humidity_sensor_sequencer_knx
  import hssk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // bus_ok, read_ok, read_data[31:0], zero pad
  input  logic [1:0]  in_tuser,   // action
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // start_status, read_request, done_res, meas_state,
                                  // humidity_raw, temperature_raw, humidity_knx,
                                  // temperature_knx, phase, zero pad
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_MH   = 3'd1;  // humidity product
  localparam logic [2:0] S_MT   = 3'd2;  // temperature product
  localparam logic [2:0] S_NH   = 3'd3;  // normalize humidity
  localparam logic [2:0] S_NT   = 3'd4;  // normalize temperature

  // registers
  logic [15:0] startup_r, startup_nxt;
  logic [15:0] measure_r, measure_nxt;
  logic [15:0] timeout_r, timeout_nxt;

  logic [2:0]  st_r, st_nxt;
  logic [2:0]  phase_r, phase_nxt;
  tmr_t        wait_r, wait_nxt;
  logic [31:0] raw_r, raw_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] hr_r, hr_nxt;
  logic [15:0] tr_r, tr_nxt;
  logic [15:0] hk_r, hk_nxt;
  logic [15:0] tk_r, tk_nxt;
  logic [1:0]  mstat_r, mstat_nxt;

  logic [28:0]        prod_r, prod_nxt;
  logic signed [15:0] mant_r, mant_nxt;
  logic [3:0]         exp_r, exp_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        oreq_r, oreq_nxt;
  logic        odone_r, odone_nxt;

  // input fields
  logic [1:0]  in_action;
  logic        in_bus_ok;
  logic        in_read_ok;
  logic [31:0] in_read_data;
  logic        in_acc;

  assign in_action    = in_tuser;
  assign in_bus_ok    = in_tdata[0];
  assign in_read_ok   = in_tdata[1];
  assign in_read_data = in_tdata[33:2];

  assign in_tready = (st_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  // wait counter: expires when it is at zero or reaches zero on this tick
  logic tmr_expire;
  tmr_t tmr_dec;
  assign tmr_expire = (wait_r == '0) || (wait_r == tmr_t'(1));
  assign tmr_dec    = (wait_r == '0) ? '0 : wait_r - tmr_t'(1);

  // raw fields of the stored word
  logic [13:0] raw_hum;
  logic [13:0] raw_tmp;
  assign raw_hum = raw_r[29:16];
  assign raw_tmp = raw_r[15:2];

  // shared multiplier, one product per cycle
  logic [13:0] mul_a;
  logic [14:0] mul_b;
  logic [28:0] mul_p;
  assign mul_a = (st_r == S_MH) ? raw_hum : raw_tmp;
  assign mul_b = (st_r == S_MH) ? HUM_SCALE : TEMP_SCALE;
  assign mul_p = {15'd0, mul_a} * {14'd0, mul_b};

  // shared normalizer check
  logic mant_ok;
  assign mant_ok = (mant_r <= MANT_MAX) && (mant_r >= MANT_MIN);

  // temperature mantissa before normalizing: scaled value minus offset
  logic [15:0] tmp_base;
  assign tmp_base = {1'b0, prod_r[28:FRAC_BITS]} - TEMP_OFFSET;

  // register port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_STARTUP: cfg_prdata = {16'd0, startup_r};
      REG_MEASURE: cfg_prdata = {16'd0, measure_r};
      REG_TIMEOUT: cfg_prdata = {16'd0, timeout_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    startup_nxt = startup_r;
    measure_nxt = measure_r;
    timeout_nxt = timeout_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_STARTUP: startup_nxt = cfg_pwdata[15:0];
        REG_MEASURE: measure_nxt = cfg_pwdata[15:0];
        REG_TIMEOUT: timeout_nxt = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // main sequencer
  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    wait_nxt      = wait_r;
    raw_nxt       = raw_r;
    pend_nxt      = pend_r;
    hr_nxt        = hr_r;
    tr_nxt        = tr_r;
    hk_nxt        = hk_r;
    tk_nxt        = tk_r;
    mstat_nxt     = mstat_r;
    prod_nxt      = prod_r;
    mant_nxt      = mant_r;
    exp_nxt       = exp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ost_nxt       = ost_r;
    oreq_nxt      = oreq_r;
    odone_nxt     = odone_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          ost_nxt       = START_ACCEPTED;
          oreq_nxt      = 1'b0;
          odone_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          unique case (in_action)
            ACT_START: begin
              if (phase_r != PH_IDLE) begin
                ost_nxt = START_NOT_IDLE;
              end else if (in_bus_ok) begin
                pend_nxt  = 1'b1;
                phase_nxt = PH_MEASURING;
                wait_nxt  = tmr_load(measure_r);
              end else begin
                ost_nxt = START_REFUSED;
              end
            end
            ACT_RESET: begin
              // pending requester survives a sensor reset
              phase_nxt = PH_STARTUP;
              wait_nxt  = tmr_load(startup_r);
            end
            ACT_DONE: begin
              // completions outside the reading phase are dropped
              if (phase_r == PH_READING) begin
                if (in_read_ok) begin
                  raw_nxt   = in_read_data;
                  phase_nxt = PH_FINISH;
                end else begin
                  phase_nxt = PH_ERROR;
                end
              end
            end
            default: begin
              // tick
              case (phase_r)
                PH_STARTUP: begin
                  wait_nxt = tmr_dec;
                  if (tmr_expire) phase_nxt = PH_IDLE;
                end
                PH_MEASURING: begin
                  wait_nxt = tmr_dec;
                  if (tmr_expire) begin
                    // a refused read stays measuring and retries next tick
                    oreq_nxt = 1'b1;
                    if (in_bus_ok) begin
                      phase_nxt = PH_READING;
                      wait_nxt  = tmr_load(timeout_r);
                    end
                  end
                end
                PH_READING: begin
                  wait_nxt = tmr_dec;
                  if (tmr_expire) phase_nxt = PH_ERROR;
                end
                PH_FINISH: begin
                  if (!raw_r[31]) begin
                    // ok or stale: convert in the multiply and normalize states
                    out_valid_nxt = 1'b0;
                    st_nxt        = S_MH;
                  end else begin
                    mstat_nxt = MEAS_ERROR;
                    phase_nxt = PH_ERROR;
                  end
                end
                PH_READY: begin
                  if (pend_r) begin
                    odone_nxt = 1'b1;
                    pend_nxt  = 1'b0;
                  end
                  phase_nxt = PH_IDLE;
                end
                PH_ERROR: begin
                  hr_nxt    = RAW_ERR;
                  tr_nxt    = RAW_ERR;
                  hk_nxt    = KNX_ERR;
                  tk_nxt    = KNX_ERR;
                  mstat_nxt = MEAS_ERROR;
                  if (pend_r) begin
                    odone_nxt = 1'b1;
                    pend_nxt  = 1'b0;
                  end
                  phase_nxt = PH_IDLE;
                end
                default: ;
              endcase
            end
          endcase
        end
      end
      S_MH: begin
        prod_nxt = mul_p;
        st_nxt   = S_MT;
      end
      S_MT: begin
        // humidity stays below 10000, never negative
        mant_nxt = $signed({1'b0, prod_r[28:FRAC_BITS]});
        exp_nxt  = 4'd0;
        prod_nxt = mul_p;
        st_nxt   = S_NH;
      end
      S_NH: begin
        if (!mant_ok) begin
          mant_nxt = mant_r >>> 1;
          exp_nxt  = exp_r + 4'd1;
        end else begin
          hk_nxt   = knx_pack(mant_r, exp_r);
          mant_nxt = $signed(tmp_base);
          exp_nxt  = 4'd0;
          st_nxt   = S_NT;
        end
      end
      S_NT: begin
        if (!mant_ok) begin
          mant_nxt = mant_r >>> 1;
          exp_nxt  = exp_r + 4'd1;
        end else begin
          tk_nxt        = knx_pack(mant_r, exp_r);
          hr_nxt        = {2'd0, raw_hum};
          tr_nxt        = {2'd0, raw_tmp};
          mstat_nxt     = raw_r[30] ? MEAS_STALE : MEAS_OK;
          phase_nxt     = PH_READY;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_r   <= STARTUP_RST;
      measure_r   <= MEASURE_RST;
      timeout_r   <= TIMEOUT_RST;
      st_r        <= S_IDLE;
      phase_r     <= PH_IDLE;
      wait_r      <= '0;
      raw_r       <= '0;
      pend_r      <= 1'b0;
      hr_r        <= '0;
      tr_r        <= '0;
      hk_r        <= '0;
      tk_r        <= '0;
      mstat_r     <= MEAS_OK;
      out_valid_r <= 1'b0;
    end else begin
      startup_r   <= startup_nxt;
      measure_r   <= measure_nxt;
      timeout_r   <= timeout_nxt;
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      wait_r      <= wait_nxt;
      raw_r       <= raw_nxt;
      pend_r      <= pend_nxt;
      hr_r        <= hr_nxt;
      tr_r        <= tr_nxt;
      hk_r        <= hk_nxt;
      tk_r        <= tk_nxt;
      mstat_r     <= mstat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    mant_r  <= mant_nxt;
    exp_r   <= exp_nxt;
    ost_r   <= ost_nxt;
    oreq_r  <= oreq_nxt;
    odone_r <= odone_nxt;
  end

  // result item
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, phase_r, tk_r, hk_r, tr_r, hr_r, mstat_r,
                       odone_r, oreq_r, ost_r};

  // checks
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_NH || st_r == S_NT) |-> exp_r <= 4'd4)
    else $error("normalizer took too many shifts");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !(in_action == ACT_TICK && phase_r == PH_FINISH)) |=> out_tvalid)
    else $error("result missing one cycle after item");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && odone_r) |-> (phase_r == PH_IDLE && !pend_r))
    else $error("delivery without return to idle");

  a_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && oreq_r) |-> (phase_r == PH_MEASURING || phase_r == PH_READING))
    else $error("read request outside measuring or reading");

  a_conv_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_NT && mant_ok) |=> (phase_r == PH_READY && out_valid_r))
    else $error("conversion end did not post a result");

endmodule

// ===== tb/humidity_sensor_sequencer_knx_test.sv =====
`timescale 1ns / 100ps

module humidity_sensor_sequencer_knx_test;
  import hssk_pkg::*;

  // cycles with no item moving on either side before the run is abandoned
  localparam int STALL_LIMIT   = 1000;
  // quiet cycles after the last readout, well above the slowest float conversion
  localparam int SETTLE_CYCLES = 20;

  // one readout as it sits in out_tdata, first member in the highest bits
  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] temp_knx;
    logic [15:0] hum_knx;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic [1:0]  meas_state;
    logic        done_res;
    logic        read_request;
    logic [1:0]  start_status;
  } readout_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;   // bus_ok, read_ok, read_data[31:0], zero pad
  logic [1:0]  in_tuser    = ACT_TICK;  // action
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [79:0] out_tdata;  // start_status, read_request, done_res, meas_state,
                           // humidity_raw, temperature_raw, humidity_knx,
                           // temperature_knx, phase, zero pad
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // idling odds in percent for each side
  int send_gap_pct = 22;
  int recv_gap_pct = 55;

  // set while in_tvalid is (or is about to be) high for an item
  bit item_offered;

  readout_t pending_readouts[$];
  int       mismatch_count;
  int       readout_count;
  int       stall_cycles;

  // predictor copy of the registers
  logic [15:0] startup_len;
  logic [15:0] measure_len;
  logic [15:0] timeout_len;

  // predictor copy of the sequencer state
  logic [2:0]  sensor_phase;
  logic [15:0] wait_left;
  logic [31:0] sample_word;
  logic        requester_waiting;
  logic [15:0] hum_raw_st;
  logic [15:0] temp_raw_st;
  logic [15:0] hum_knx_st;
  logic [15:0] temp_knx_st;
  logic [1:0]  meas_status;

  humidity_sensor_sequencer_knx dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_sensor_model();
    startup_len       = STARTUP_RST;
    measure_len       = MEASURE_RST;
    timeout_len       = TIMEOUT_RST;
    sensor_phase      = PH_IDLE;
    wait_left         = '0;
    sample_word       = '0;
    requester_waiting = 1'b0;
    hum_raw_st        = '0;
    temp_raw_st       = '0;
    hum_knx_st        = '0;
    temp_knx_st       = '0;
    meas_status       = MEAS_OK;
  endfunction

  // a wait of zero expires on the first tick, a wait of n on the n-th
  function automatic bit wait_expired();
    if (wait_left == '0) return 1'b1;
    wait_left = wait_left - 16'd1;
    return wait_left == '0;
  endfunction

  // 2-byte float: arithmetic shifts until the mantissa fits in 11 bits plus sign
  function automatic logic [15:0] knx_float(input logic signed [31:0] mant);
    logic signed [31:0] m;
    logic [3:0]         shifts;
    m      = mant;
    shifts = '0;
    while (m > MANT_MAX || m < MANT_MIN) begin
      m      = m >>> 1;
      shifts = shifts + 4'd1;
    end
    return {m[31], shifts, m[10:0]};
  endfunction

  // sensor status codes 0 and 1 line up with ok and stale
  function automatic void decode_sample();
    logic [1:0]  status;
    logic [13:0] hum;
    logic [13:0] temp;
    logic [31:0] hum_scaled;
    logic [31:0] temp_scaled;
    status = sample_word[31:30];
    hum    = sample_word[29:16];
    temp   = sample_word[15:2];
    if (status <= MEAS_STALE) begin
      hum_scaled  = (32'(hum) * HUM_SCALE) >> FRAC_BITS;
      temp_scaled = ((32'(temp) * TEMP_SCALE) >> FRAC_BITS) - 32'(TEMP_OFFSET);
      hum_raw_st   = 16'(hum);
      temp_raw_st  = 16'(temp);
      hum_knx_st   = knx_float(hum_scaled);
      temp_knx_st  = knx_float(temp_scaled);
      meas_status  = status;
      sensor_phase = PH_READY;
    end else begin
      meas_status  = MEAS_ERROR;
      sensor_phase = PH_ERROR;
    end
  endfunction

  function automatic readout_t advance_sensor(input logic [1:0] action, input logic bus_ok,
                                              input logic read_ok, input logic [31:0] word);
    readout_t r;
    r = '0;
    r.start_status = START_ACCEPTED;
    case (action)
      ACT_START: begin
        if (sensor_phase != PH_IDLE) begin
          r.start_status = START_NOT_IDLE;
        end else if (bus_ok) begin
          requester_waiting = 1'b1;
          sensor_phase      = PH_MEASURING;
          wait_left         = measure_len;  // 16-bit register never saturates the timer
        end else begin
          r.start_status = START_REFUSED;
        end
      end
      ACT_RESET: begin
        // pending requester survives a sensor reset
        sensor_phase = PH_STARTUP;
        wait_left    = startup_len;
      end
      ACT_DONE: begin
        // completions outside the reading phase are dropped
        if (sensor_phase == PH_READING) begin
          if (read_ok) begin
            sample_word  = word;
            sensor_phase = PH_FINISH;
          end else begin
            sensor_phase = PH_ERROR;
          end
        end
      end
      ACT_TICK: begin
        case (sensor_phase)
          PH_STARTUP: begin
            if (wait_expired()) sensor_phase = PH_IDLE;
          end
          PH_MEASURING: begin
            // a refused read is presented again on the next tick
            if (wait_expired()) begin
              r.read_request = 1'b1;
              if (bus_ok) begin
                sensor_phase = PH_READING;
                wait_left    = timeout_len;
              end
            end
          end
          PH_READING: begin
            if (wait_expired()) sensor_phase = PH_ERROR;
          end
          PH_FINISH: begin
            decode_sample();
          end
          PH_READY: begin
            r.done_res        = requester_waiting;
            requester_waiting = 1'b0;
            sensor_phase      = PH_IDLE;
          end
          PH_ERROR: begin
            hum_raw_st        = RAW_ERR;
            temp_raw_st       = RAW_ERR;
            hum_knx_st        = KNX_ERR;
            temp_knx_st       = KNX_ERR;
            meas_status       = MEAS_ERROR;
            r.done_res        = requester_waiting;
            requester_waiting = 1'b0;
            sensor_phase      = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
    endcase
    // stored result shows on every readout
    r.meas_state = meas_status;
    r.hum_raw    = hum_raw_st;
    r.temp_raw   = temp_raw_st;
    r.hum_knx    = hum_knx_st;
    r.temp_knx   = temp_knx_st;
    r.phase      = sensor_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // only drops valid when it is up, so a step never sees two assignments to it
  task automatic lower_valid();
    if (item_offered) begin
      in_tvalid    <= 1'b0;
      item_offered = 1'b0;
    end
  endtask

  // sender holds off until every readout has come back
  task automatic wait_drained();
    lower_valid();
    do @(posedge clk); while (pending_readouts.size() != 0);
  endtask

  // setup and access phases, then the bus is released before the task returns
  task automatic cfg_write(input logic [1:0] index, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      REG_STARTUP: startup_len = value;
      REG_MEASURE: measure_len = value;
      default:     timeout_len = value;
    endcase
    @(posedge clk);
  endtask

  // registers change only with the block drained
  task automatic set_timing(input logic [15:0] startup, input logic [15:0] measure,
                            input logic [15:0] timeout);
    wait_drained();
    cfg_write(REG_STARTUP, startup);
    cfg_write(REG_MEASURE, measure);
    cfg_write(REG_TIMEOUT, timeout);
  endtask

  task automatic send_item(input logic [1:0] action, input logic bus_ok, input logic read_ok,
                           input logic [31:0] word);
    if ($urandom_range(99) < send_gap_pct) begin
      lower_valid();
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid    <= 1'b1;
    in_tuser     <= action;
    in_tdata     <= {6'd0, word, read_ok, bus_ok};
    item_offered = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_readouts.push_back(advance_sensor(action, bus_ok, read_ok, word));
  endtask

  // mostly good status codes so that most reads produce readings
  function automatic logic [31:0] sensor_word();
    logic [1:0] status;
    status = ($urandom_range(4) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1, 0));
    return {status, 30'($urandom)};
  endfunction

  // next item shaped by the predicted phase, so measurements run to the end
  task automatic random_item();
    int          pick;
    logic [1:0]  action;
    logic        bus_ok;
    logic        read_ok;
    logic [31:0] word;
    pick    = $urandom_range(99);
    bus_ok  = $urandom_range(9) != 0;
    read_ok = $urandom_range(9) != 0;
    word    = $urandom;
    if ($urandom_range(99) == 0) wait_drained();
    case (sensor_phase)
      PH_IDLE: begin
        action = (pick < 55) ? ACT_START : (pick < 85) ? ACT_TICK :
                 (pick < 93) ? ACT_RESET : ACT_DONE;
      end
      PH_READING: begin
        action = (pick < 50) ? ACT_DONE : (pick < 92) ? ACT_TICK :
                 (pick < 96) ? ACT_START : ACT_RESET;
        word   = sensor_word();
      end
      default: begin
        action = (pick < 85) ? ACT_TICK : (pick < 92) ? ACT_START :
                 (pick < 96) ? ACT_DONE : ACT_RESET;
      end
    endcase
    send_item(action, bus_ok, read_ok, word);
  endtask

  // receiver stalls at the current odds
  always @(posedge clk) begin
    out_tready <= $urandom_range(99) >= recv_gap_pct;
  end

  // ---------------------------------------------------------------------------
  // readout checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("readout %0d: %s expected %0h got %0h", readout_count, name, want, seen);
    end
  endfunction

  always @(posedge clk) begin : check_readouts
    readout_t seen;
    readout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = readout_t'(out_tdata[72:0]);
      if (pending_readouts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("readout %0d: none expected, got %0h", readout_count, seen);
      end else begin
        want = pending_readouts.pop_front();
        check_field("start_status", 32'(want.start_status), 32'(seen.start_status));
        check_field("read_request", 32'(want.read_request), 32'(seen.read_request));
        check_field("done_res", 32'(want.done_res), 32'(seen.done_res));
        check_field("meas_state", 32'(want.meas_state), 32'(seen.meas_state));
        check_field("humidity_raw", 32'(want.hum_raw), 32'(seen.hum_raw));
        check_field("temperature_raw", 32'(want.temp_raw), 32'(seen.temp_raw));
        check_field("humidity_knx", 32'(want.hum_knx), 32'(seen.hum_knx));
        check_field("temperature_knx", 32'(want.temp_knx), 32'(seen.temp_knx));
        check_field("phase", 32'(want.phase), 32'(seen.phase));
      end
      readout_count++;
    end
  end

  // watchdog: any item moving on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero waits: completion while idle, start answers, refused read, largest readings
  task automatic test_start_and_read();
    set_timing(16'd0, 16'd0, 16'd0);
    send_item(ACT_DONE, 1'b1, 1'b1, 32'hffff_ffff);   // dropped, not reading
    send_item(ACT_START, 1'b0, 1'b0, 32'h0);          // bus refuses the start
    send_item(ACT_START, 1'b1, 1'b0, 32'h0);
    send_item(ACT_START, 1'b1, 1'b1, 32'h0);          // already measuring
    send_item(ACT_TICK, 1'b0, 1'b0, 32'h0);           // read refused, stays measuring
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    send_item(ACT_DONE, 1'b1, 1'b1, 32'h3fff_ffff);   // full-scale humidity and temperature
    send_item(ACT_TICK, 1'b1, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b0, 1'b1, 32'h0);           // delivery
  endtask

  // sensor reset while reading keeps the requester, then a read timeout
  task automatic test_sensor_reset();
    send_item(ACT_START, 1'b1, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    send_item(ACT_RESET, 1'b0, 1'b1, 32'hffff_ffff);
    send_item(ACT_TICK, 1'b0, 1'b0, 32'h0);
    send_item(ACT_START, 1'b1, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);           // zero timeout expires
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);           // error delivered
  endtask

  // failed transfer, then stale data with zero readings (negative temperature)
  task automatic test_read_outcomes();
    send_item(ACT_START, 1'b1, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    send_item(ACT_DONE, 1'b1, 1'b0, 32'h1234_5678);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    send_item(ACT_START, 1'b1, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    send_item(ACT_DONE, 1'b0, 1'b1, 32'h4000_0003);   // low two bits are not data
    send_item(ACT_TICK, 1'b0, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b0, 1'b0, 32'h0);
  endtask

  // largest waits: stuck measuring and in startup, then a long read window
  task automatic test_config_extremes();
    set_timing(16'hffff, 16'hffff, 16'hffff);
    send_item(ACT_START, 1'b1, 1'b0, 32'h0);
    repeat (3) send_item(ACT_TICK, 1'b1, 1'b1, $urandom);
    send_item(ACT_RESET, 1'b1, 1'b1, 32'h0);
    repeat (3) send_item(ACT_TICK, 1'b1, 1'b1, $urandom);
    set_timing(16'd0, 16'd0, 16'hffff);
    send_item(ACT_RESET, 1'b0, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b0, 1'b0, 32'h0);
    send_item(ACT_START, 1'b1, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    repeat (3) send_item(ACT_TICK, 1'b1, 1'b0, $urandom);
    send_item(ACT_DONE, 1'b1, 1'b1, sensor_word());
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 1'b0, 32'h0);
  endtask

  task automatic test_random_traffic(input int items, input logic [15:0] startup,
                                     input logic [15:0] measure, input logic [15:0] timeout);
    set_timing(startup, measure, timeout);
    repeat (items) random_item();
  endtask

  initial begin
    reset_sensor_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    test_start_and_read();
    test_sensor_reset();
    test_read_outcomes();
    test_config_extremes();
    test_random_traffic(350, 16'($urandom_range(3)), 16'($urandom_range(6)),
                        16'($urandom_range(4)));
    test_random_traffic(350, 16'd0, 16'd0, 16'd0);

    // roles swapped
    wait_drained();
    send_gap_pct = 55;
    recv_gap_pct = 22;
    test_random_traffic(350, 16'($urandom_range(3)), 16'($urandom_range(6)),
                        16'($urandom_range(4)));
    test_random_traffic(300, STARTUP_RST, MEASURE_RST, TIMEOUT_RST);

    // back to back on both sides
    wait_drained();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(350, 16'($urandom_range(3)), 16'($urandom_range(6)),
                        16'($urandom_range(4)));
    test_random_traffic(350, 16'd1, 16'd2, 16'd1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_readouts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
